// ----- design/rmq_pkg.sv -----
package rmq_pkg;

    localparam int FRACTION_BITS_DEF = 14;
    localparam int MAG_W = 32;
    localparam int SUM_W = 64;
    localparam int LEN_W = 32;
    localparam int NORM_BIT = 29;

    localparam logic [1:0] BR_TRACE = 2'd0;
    localparam logic [1:0] BR_R0C0 = 2'd1;
    localparam logic [1:0] BR_R1C1 = 2'd2;
    localparam logic [1:0] BR_R2C2 = 2'd3;

    typedef struct packed {
        logic [1:0]            branch;
        logic                  bad;
        logic [3:0]            neg;
        logic [3:0][MAG_W-1:0] mag;
    } meta_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic signed [15:0] w;
        logic [1:0]         branch;
        logic               degenerate;
    } res_t;

endpackage

// ----- design/rmq_front.sv -----
module rmq_front #(
    parameter int FRACTION_BITS = rmq_pkg::FRACTION_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic [8:0][15:0]                m,
    output logic                            out_valid,
    output logic [rmq_pkg::SUM_W-1:0]       out_sum,
    output rmq_pkg::meta_t                  out_meta
);

    localparam int VW = rmq_pkg::MAG_W + 1;
    localparam int MW = rmq_pkg::MAG_W;
    localparam logic signed [VW-1:0] ONE_V = VW'(64'd1 << FRACTION_BITS);

    logic signed [VW-1:0] e [9];
    logic signed [VW-1:0] t;
    logic signed [VW-1:0] a;
    logic signed [VW-1:0] v [4];
    logic [1:0]           br;

    logic [4:0]            valid_reg;
    logic signed [VW-1:0]  v_reg [4];
    logic [1:0]            br1_reg;
    logic                  bad1_reg;
    rmq_pkg::meta_t        m2_reg, m3_reg, m4_reg, m5_reg;
    logic [MW-1:0]         mx2_reg;
    logic [3:0][2*MW-1:0]  sq4_reg;
    logic [rmq_pkg::SUM_W-1:0] sum5_reg;

    logic [MW-1:0] mag_c [4];
    logic [MW-1:0] mx_a, mx_b, mx_c;
    logic [4:0]    msb;
    logic [4:0]    shamt;

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            e[i] = VW'($signed(m[i]));
        end
        t = e[0] + e[4] + e[8];
        a = ONE_V;
        if (t > 0)
        begin
            br   = rmq_pkg::BR_TRACE;
            v[0] = e[5] - e[7];
            v[1] = e[6] - e[2];
            v[2] = e[1] - e[3];
            v[3] = t + ONE_V;
        end
        else if (e[0] > e[4] && e[0] > e[8])
        begin
            br   = rmq_pkg::BR_R0C0;
            a    = ONE_V + e[0] - e[4] - e[8];
            v[0] = a;
            v[1] = e[3] + e[1];
            v[2] = e[6] + e[2];
            v[3] = e[5] - e[7];
        end
        else if (e[4] > e[8])
        begin
            br   = rmq_pkg::BR_R1C1;
            a    = ONE_V + e[4] - e[0] - e[8];
            v[0] = e[3] + e[1];
            v[1] = a;
            v[2] = e[7] + e[5];
            v[3] = e[6] - e[2];
        end
        else
        begin
            br   = rmq_pkg::BR_R2C2;
            a    = ONE_V + e[8] - e[4] - e[0];
            v[0] = e[6] + e[2];
            v[1] = e[5] + e[7];
            v[2] = a;
            v[3] = e[1] - e[3];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            mag_c[i] = v_reg[i][VW-1] ? MW'(-v_reg[i]) : MW'(v_reg[i]);
        end
        mx_a = (mag_c[0] > mag_c[1]) ? mag_c[0] : mag_c[1];
        mx_b = (mag_c[2] > mag_c[3]) ? mag_c[2] : mag_c[3];
        mx_c = (mx_a > mx_b) ? mx_a : mx_b;
    end

    // shift that brings the largest magnitude up to the normalizing bit
    always_comb
    begin
        msb = 5'd0;
        for (int i = 0; i < rmq_pkg::NORM_BIT; i++)
        begin
            if (mx2_reg[i])
            begin
                msb = 5'(i);
            end
        end
        if (mx2_reg == '0 || mx2_reg >= (MW'(1) << rmq_pkg::NORM_BIT))
        begin
            shamt = 5'd0;
        end
        else
        begin
            shamt = 5'(rmq_pkg::NORM_BIT) - msb;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                v_reg[i] <= v[i];
            end
            br1_reg  <= br;
            bad1_reg <= (br != rmq_pkg::BR_TRACE) && (a <= 0);

            m2_reg.branch <= br1_reg;
            m2_reg.bad    <= bad1_reg;
            for (int i = 0; i < 4; i++)
            begin
                m2_reg.neg[i] <= v_reg[i][VW-1];
                m2_reg.mag[i] <= mag_c[i];
            end
            mx2_reg <= mx_c;

            m3_reg.branch <= m2_reg.branch;
            m3_reg.bad    <= m2_reg.bad;
            m3_reg.neg    <= m2_reg.neg;
            for (int i = 0; i < 4; i++)
            begin
                m3_reg.mag[i] <= m2_reg.mag[i] << shamt;
            end

            m4_reg <= m3_reg;
            for (int i = 0; i < 4; i++)
            begin
                sq4_reg[i] <= (2*MW)'(m3_reg.mag[i]) * (2*MW)'(m3_reg.mag[i]);
            end

            m5_reg   <= m4_reg;
            sum5_reg <= rmq_pkg::SUM_W'(sq4_reg[0] + sq4_reg[1] + sq4_reg[2] + sq4_reg[3]);
        end
    end

    assign out_valid = valid_reg[4];
    assign out_sum   = sum5_reg;
    assign out_meta  = m5_reg;

endmodule

// ----- design/rmq_isqrt.sv -----
module rmq_isqrt (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [rmq_pkg::SUM_W-1:0]    in_sum,
    input  rmq_pkg::meta_t               in_meta,
    output logic                         out_valid,
    output logic [rmq_pkg::LEN_W-1:0]    out_len,
    output rmq_pkg::meta_t               out_meta
);

    localparam int SW = rmq_pkg::SUM_W;
    localparam int STEPS = SW / 2;

    logic [STEPS:1]  valid_reg;
    logic [SW-1:0]   n_reg [STEPS+1];
    logic [SW-1:0]   res_reg [STEPS+1];
    rmq_pkg::meta_t  meta_reg [STEPS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[STEPS-1:1], in_valid};
        end
    end

    // one result bit per stage, bit weight falling by four each step
    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        localparam logic [SW-1:0] BIT = SW'(1) << (SW - 2 - 2*k);
        logic [SW-1:0]  n_src;
        logic [SW-1:0]  res_src;
        rmq_pkg::meta_t meta_src;
        logic [SW-1:0]  trial;

        if (k == 0)
        begin : g_first
            assign n_src    = in_sum;
            assign res_src  = '0;
            assign meta_src = in_meta;
        end
        else
        begin : g_rest
            assign n_src    = n_reg[k];
            assign res_src  = res_reg[k];
            assign meta_src = meta_reg[k];
        end

        assign trial = res_src + BIT;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                meta_reg[k+1] <= meta_src;
                if (n_src >= trial)
                begin
                    n_reg[k+1]   <= n_src - trial;
                    res_reg[k+1] <= (res_src >> 1) + BIT;
                end
                else
                begin
                    n_reg[k+1]   <= n_src;
                    res_reg[k+1] <= res_src >> 1;
                end
            end
        end
    end

    assign out_valid = valid_reg[STEPS];
    assign out_len   = res_reg[STEPS][rmq_pkg::LEN_W-1:0];
    assign out_meta  = meta_reg[STEPS];

endmodule

// ----- design/rmq_div.sv -----
module rmq_div #(
    parameter int FRACTION_BITS = rmq_pkg::FRACTION_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [rmq_pkg::LEN_W-1:0]     in_len,
    input  rmq_pkg::meta_t                in_meta,
    output logic                          out_valid,
    output logic [3:0][FRACTION_BITS:0]   out_q,
    output rmq_pkg::meta_t                out_meta
);

    localparam int QW = FRACTION_BITS + 1;
    localparam int NW = rmq_pkg::MAG_W + FRACTION_BITS + 2;
    localparam int DW = rmq_pkg::LEN_W + 1;

    logic [QW+1:1]          valid_reg;
    logic [3:0][NW-1:0]     rem_reg [QW+1];
    logic [3:0][QW-1:0]     q_reg [QW+1];
    logic [DW-1:0]          d_reg [QW+1];
    rmq_pkg::meta_t         meta_reg [QW+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[QW:1], in_valid};
        end
    end

    // rounded dividend and doubled length
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 4; l++)
            begin
                rem_reg[0][l] <= (NW'(in_meta.mag[l]) << (FRACTION_BITS + 1)) + NW'(in_len);
                q_reg[0][l]   <= '0;
            end
            d_reg[0]           <= {in_len, 1'b0};
            meta_reg[0].branch <= in_meta.branch;
            meta_reg[0].neg    <= in_meta.neg;
            meta_reg[0].mag    <= in_meta.mag;
            meta_reg[0].bad    <= in_meta.bad || (in_len == '0);
        end
    end

    for (genvar j = 0; j < QW; j++)
    begin : g_step
        localparam int SH = QW - 1 - j;
        logic [NW-1:0] dsh;

        assign dsh = NW'(d_reg[j]) << SH;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_reg[j+1]    <= d_reg[j];
                meta_reg[j+1] <= meta_reg[j];
                for (int l = 0; l < 4; l++)
                begin
                    if (rem_reg[j][l] >= dsh)
                    begin
                        rem_reg[j+1][l] <= rem_reg[j][l] - dsh;
                        q_reg[j+1][l]   <= q_reg[j][l] | (QW'(1) << SH);
                    end
                    else
                    begin
                        rem_reg[j+1][l] <= rem_reg[j][l];
                        q_reg[j+1][l]   <= q_reg[j][l];
                    end
                end
            end
        end
    end

    assign out_valid = valid_reg[QW+1];
    assign out_q     = q_reg[QW];
    assign out_meta  = meta_reg[QW];

endmodule

// ----- design/rotation_matrix_to_quaternion_unit.sv -----
// Converts a 3x3 rotation matrix in signed fixed point (FRACTION_BITS fraction bits,
// default Q2.14) to a unit quaternion with the four-branch trace method: positive trace,
// else the largest diagonal element, ties going to the later element. The branch vector
// is normalized by its length, components rounded to nearest with halves away from zero
// and saturated to 16 bits. A non-positive root argument or zero length gives the
// identity quaternion with degenerate set. Fully pipelined: one matrix per cycle while the
// skid register is empty, through 5 front-end stages, 32 square-root stages,
// FRACTION_BITS + 2 divider stages and one output stage; root and divider are bit-per-stage.
// An output skid register lets the unit take one more matrix while a result waits.
module rotation_matrix_to_quaternion_unit #(
    parameter int FRACTION_BITS = rmq_pkg::FRACTION_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] m_r0c0,
    input  logic signed [15:0] m_r0c1,
    input  logic signed [15:0] m_r0c2,
    input  logic signed [15:0] m_r1c0,
    input  logic signed [15:0] m_r1c1,
    input  logic signed [15:0] m_r1c2,
    input  logic signed [15:0] m_r2c0,
    input  logic signed [15:0] m_r2c1,
    input  logic signed [15:0] m_r2c2,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] quat_x,
    output logic signed [15:0] quat_y,
    output logic signed [15:0] quat_z,
    output logic signed [15:0] quat_w,
    output logic [1:0]         branch_taken,
    output logic               degenerate
);

    localparam int QW = FRACTION_BITS + 1;
    localparam logic [31:0] ONE_U = 32'(64'd1 << FRACTION_BITS);
    localparam logic [15:0] ID_W = (ONE_U > 32'd32767) ? 16'h7fff : ONE_U[15:0];

    logic                           en;
    logic [8:0][15:0]               mat;
    logic                           f_valid;
    logic [rmq_pkg::SUM_W-1:0]      f_sum;
    rmq_pkg::meta_t                 f_meta;
    logic                           s_valid;
    logic [rmq_pkg::LEN_W-1:0]      s_len;
    rmq_pkg::meta_t                 s_meta;
    logic                           d_valid;
    logic [3:0][QW-1:0]             d_q;
    rmq_pkg::meta_t                 d_meta;

    rmq_pkg::res_t res_next;
    rmq_pkg::res_t pipe_reg;
    rmq_pkg::res_t skid_reg;
    rmq_pkg::res_t show;
    logic          pipe_valid_reg;
    logic          skid_valid_reg;
    logic [15:0]   comp [4];
    logic [31:0]   q32;

    assign en       = !skid_valid_reg;
    assign in_ready = en;
    assign mat      = {m_r2c2, m_r2c1, m_r2c0, m_r1c2, m_r1c1, m_r1c0,
                       m_r0c2, m_r0c1, m_r0c0};

    rmq_front #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .m        (mat),
        .out_valid(f_valid),
        .out_sum  (f_sum),
        .out_meta (f_meta)
    );

    rmq_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (f_valid),
        .in_sum   (f_sum),
        .in_meta  (f_meta),
        .out_valid(s_valid),
        .out_len  (s_len),
        .out_meta (s_meta)
    );

    rmq_div #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_valid),
        .in_len   (s_len),
        .in_meta  (s_meta),
        .out_valid(d_valid),
        .out_q    (d_q),
        .out_meta (d_meta)
    );

    // sign, saturation and identity fallback
    always_comb
    begin
        q32 = '0;
        for (int l = 0; l < 4; l++)
        begin
            q32 = 32'(d_q[l]);
            if (d_meta.neg[l] && q32 != '0)
            begin
                comp[l] = (q32 > 32'd32768) ? 16'h8000 : 16'(32'd0 - q32);
            end
            else
            begin
                comp[l] = (q32 > 32'd32767) ? 16'h7fff : q32[15:0];
            end
        end
        res_next.branch     = d_meta.branch;
        res_next.degenerate = d_meta.bad;
        if (d_meta.bad)
        begin
            res_next.x = '0;
            res_next.y = '0;
            res_next.z = '0;
            res_next.w = $signed(ID_W);
        end
        else
        begin
            res_next.x = $signed(comp[0]);
            res_next.y = $signed(comp[1]);
            res_next.z = $signed(comp[2]);
            res_next.w = $signed(comp[3]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                pipe_valid_reg <= d_valid;
            end
            if (skid_valid_reg && out_ready)
            begin
                skid_valid_reg <= 1'b0;
            end
            else if (!skid_valid_reg && pipe_valid_reg && !out_ready)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pipe_reg <= res_next;
        end
        if (!skid_valid_reg && pipe_valid_reg && !out_ready)
        begin
            skid_reg <= pipe_reg;
        end
    end

    assign show         = skid_valid_reg ? skid_reg : pipe_reg;
    assign out_valid    = skid_valid_reg || pipe_valid_reg;
    assign quat_x       = show.x;
    assign quat_y       = show.y;
    assign quat_z       = show.z;
    assign quat_w       = show.w;
    assign branch_taken = show.branch;
    assign degenerate   = show.degenerate;

    a_deg_identity: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> quat_x == '0 && quat_y == '0 && quat_z == '0)
        else $error("degenerate beat without identity vector");

    a_trace_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && branch_taken == rmq_pkg::BR_TRACE |-> !degenerate)
        else $error("positive trace branch flagged degenerate");

    a_skid_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(pipe_valid_reg) && !$past(out_ready))
        else $error("skid loaded without a stalled beat");

    a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && !out_ready |=> skid_valid_reg && !in_ready)
        else $error("skid beat dropped while stalled");

endmodule

// ----- tb/sv/rmq_checker.sv -----
module rmq_checker #(
    parameter int FRACTION_BITS = rmq_pkg::FRACTION_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic signed [15:0] m_r0c0,
    input  logic signed [15:0] m_r0c1,
    input  logic signed [15:0] m_r0c2,
    input  logic signed [15:0] m_r1c0,
    input  logic signed [15:0] m_r1c1,
    input  logic signed [15:0] m_r1c2,
    input  logic signed [15:0] m_r2c0,
    input  logic signed [15:0] m_r2c1,
    input  logic signed [15:0] m_r2c2,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    input  logic signed [15:0] quat_w,
    input  logic [1:0]         branch_taken,
    input  logic               degenerate,
    output int                 errors,
    output int                 pending,
    output int                 quats_seen,
    output int                 degen_seen,
    output int                 branch_hits [4]
);

    rmq_pkg::res_t quat_fifo[$];

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [15:0] sat16(bit neg, longint unsigned mag);
        if (neg)
        begin
            if (mag > 32768) mag = 32768;
            return 16'(-longint'(mag));
        end
        if (mag > 32767) mag = 32767;
        return 16'(mag);
    endfunction

    function automatic rmq_pkg::res_t matrix_to_quat(longint e00, longint e01, longint e02,
                                                     longint e10, longint e11, longint e12,
                                                     longint e20, longint e21, longint e22);
        longint one;
        longint tr;
        longint a;
        longint v [4];
        longint unsigned mag [4];
        bit neg [4];
        longint unsigned mx;
        longint unsigned s;
        longint unsigned len;
        longint unsigned q;
        logic [15:0] c [4];
        rmq_pkg::res_t r;
        one = longint'(1) << FRACTION_BITS;
        a = 1;
        tr = e00 + e11 + e22;
        if (tr > 0)
        begin
            r.branch = rmq_pkg::BR_TRACE;
            v = '{e12 - e21, e20 - e02, e01 - e10, tr + one};
        end
        else if (e00 > e11 && e00 > e22)
        begin
            r.branch = rmq_pkg::BR_R0C0;
            a = one + e00 - e11 - e22;
            v = '{a, e10 + e01, e20 + e02, e12 - e21};
        end
        else if (e11 > e22)
        begin
            r.branch = rmq_pkg::BR_R1C1;
            a = one + e11 - e00 - e22;
            v = '{e10 + e01, a, e21 + e12, e20 - e02};
        end
        else
        begin
            r.branch = rmq_pkg::BR_R2C2;
            a = one + e22 - e11 - e00;
            v = '{e20 + e02, e12 + e21, a, e01 - e10};
        end
        r.x = 0;
        r.y = 0;
        r.z = 0;
        r.w = sat16(1'b0, one);
        r.degenerate = 1'b1;
        if (a > 0)
        begin
            mx = 0;
            for (int i = 0; i < 4; i++)
            begin
                neg[i] = v[i] < 0;
                mag[i] = neg[i] ? -v[i] : v[i];
                if (mag[i] > mx) mx = mag[i];
            end
            while (mx != 0 && mx < (64'd1 << 29))
            begin
                for (int i = 0; i < 4; i++) mag[i] = mag[i] << 1;
                mx = mx << 1;
            end
            s = 0;
            for (int i = 0; i < 4; i++) s = s + mag[i] * mag[i];
            len = int_sqrt(s);
            if (len != 0)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    q = ((mag[i] << (FRACTION_BITS + 1)) + len) / (2 * len);
                    c[i] = sat16(neg[i] && q != 0, q);
                end
                r.x = c[0];
                r.y = c[1];
                r.z = c[2];
                r.w = c[3];
                r.degenerate = 1'b0;
            end
        end
        return r;
    endfunction

    assign pending = quat_fifo.size();

    always @(posedge clk)
    begin
        rmq_pkg::res_t want;
        if (rst_n && in_valid && in_ready)
            quat_fifo.push_back(matrix_to_quat(m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1,
                                               m_r1c2, m_r2c0, m_r2c1, m_r2c2));
        if (rst_n && out_valid && out_ready)
        begin
            quats_seen++;
            if (degenerate) degen_seen++;
            branch_hits[branch_taken]++;
            if (quat_fifo.size() == 0)
            begin
                errors++;
                $error("unexpected quaternion beat");
            end
            else
            begin
                want = quat_fifo.pop_front();
                if (quat_x !== want.x)
                begin
                    errors++;
                    $error("quat_x exp %0d got %0d", want.x, quat_x);
                end
                if (quat_y !== want.y)
                begin
                    errors++;
                    $error("quat_y exp %0d got %0d", want.y, quat_y);
                end
                if (quat_z !== want.z)
                begin
                    errors++;
                    $error("quat_z exp %0d got %0d", want.z, quat_z);
                end
                if (quat_w !== want.w)
                begin
                    errors++;
                    $error("quat_w exp %0d got %0d", want.w, quat_w);
                end
                if (branch_taken !== want.branch)
                begin
                    errors++;
                    $error("branch_taken exp %0d got %0d", want.branch, branch_taken);
                end
                if (degenerate !== want.degenerate)
                begin
                    errors++;
                    $error("degenerate exp %0d got %0d", want.degenerate, degenerate);
                end
            end
        end
    end

    initial
    begin
        errors = 0;
        quats_seen = 0;
        degen_seen = 0;
        branch_hits = '{0, 0, 0, 0};
    end
endmodule

// ----- tb/sv/tb.sv -----
module tb;

    localparam int N_RANDOM = 1930;
    localparam int LATENCY = rmq_pkg::FRACTION_BITS_DEF + 41;
    localparam int QUIET_TAIL = 300;
    localparam int CYCLE_LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [15:0] elem [9];
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [15:0] quat_x, quat_y, quat_z, quat_w;
    logic [1:0] branch_taken;
    logic degenerate;
    int errors, pending, quats_seen, degen_seen;
    int branch_hits [4];
    int cycle = 0;
    int sent = 0;
    bit quiet = 1'b0;
    bit stimulus_done = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
        for (int i = 0; i < 9; i++) elem[i] = '0;

    rotation_matrix_to_quaternion_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .m_r0c0(elem[0]), .m_r0c1(elem[1]), .m_r0c2(elem[2]),
        .m_r1c0(elem[3]), .m_r1c1(elem[4]), .m_r1c2(elem[5]),
        .m_r2c0(elem[6]), .m_r2c1(elem[7]), .m_r2c2(elem[8]),
        .out_valid(out_valid), .out_ready(out_ready),
        .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w),
        .branch_taken(branch_taken), .degenerate(degenerate)
    );

    rmq_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .m_r0c0(elem[0]), .m_r0c1(elem[1]), .m_r0c2(elem[2]),
        .m_r1c0(elem[3]), .m_r1c1(elem[4]), .m_r1c2(elem[5]),
        .m_r2c0(elem[6]), .m_r2c1(elem[7]), .m_r2c2(elem[8]),
        .out_valid(out_valid), .out_ready(out_ready),
        .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w),
        .branch_taken(branch_taken), .degenerate(degenerate),
        .errors(errors), .pending(pending), .quats_seen(quats_seen),
        .degen_seen(degen_seen), .branch_hits(branch_hits)
    );

    function automatic logic signed [15:0] rand_elem();
        case ($urandom_range(0, 5))
            0: return 16'(-32768 + $urandom_range(0, 3));
            1: return 16'(32767 - $urandom_range(0, 3));
            2: return 16'(int'($urandom_range(0, 32768)) - 16384);
            3: return 16'(int'($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    // send one matrix; valid stays up across back-to-back beats
    task automatic send_matrix(input logic signed [15:0] m [9]);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 3);
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        for (int i = 0; i < 9; i++) elem[i] <= m[i];
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    // rotation-like matrix: all diagonal entries of one random sign, or the dominant entry on a chosen diagonal slot
    task automatic build_rotation(output logic signed [15:0] m [9]);
        int d;
        int s;
        d = $urandom_range(0, 3);
        for (int i = 0; i < 9; i++) m[i] = 16'(int'($urandom_range(0, 16384)) - 8192);
        s = $urandom_range(0, 1) ? 16384 : -16384;
        case (d)
            0: begin m[0] = 16'(s); m[4] = 16'(s); m[8] = 16'(s); end
            1: begin m[0] = 16'(16384); m[4] = 16'(-16384); m[8] = 16'(-16384); end
            2: begin m[0] = 16'(-16384); m[4] = 16'(16384); m[8] = 16'(-16384); end
            default: begin m[0] = 16'(-16384); m[4] = 16'(-16384); m[8] = 16'(16384); end
        endcase
        m[0] = m[0] + 16'(int'($urandom_range(0, 2000)) - 1000);
        m[4] = m[4] + 16'(int'($urandom_range(0, 2000)) - 1000);
        m[8] = m[8] + 16'(int'($urandom_range(0, 2000)) - 1000);
    endtask

    initial
    begin
        logic signed [15:0] m [9];
        logic signed [15:0] lim [4];
        lim = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff};
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        // identity, each branch, ties, all-negative diagonals, zero matrix, extremes
        m = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384};
        send_matrix(m);
        m = '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384};
        send_matrix(m);
        m = '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384};
        send_matrix(m);
        m = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384};
        send_matrix(m);
        m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
        send_matrix(m);
        m = '{-100, 5, 6, 7, -100, 8, 9, 10, -100};
        send_matrix(m);
        m = '{-32768, 1, 2, 3, -32768, 4, 5, 6, 32767};
        send_matrix(m);
        m = '{-32768, 0, 0, 0, 32767, 0, 0, 0, -32768};
        send_matrix(m);
        m = '{0, 0, 0, 0, -32768, 0, 0, 0, -32768};
        send_matrix(m);
        m = '{-20000, 0, 0, 0, -20000, 0, 0, 0, -20000};
        send_matrix(m);
        m = '{-32768, 0, 0, 0, -32768, 0, 0, 0, 0};
        send_matrix(m);
        m = '{-16384, 0, 0, 0, -16384, 0, 0, 0, -16384};
        send_matrix(m);
        m = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767};
        send_matrix(m);
        m = '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768};
        send_matrix(m);
        m = '{-1, -1, -1, -1, -1, -1, -1, -1, -1};
        send_matrix(m);
        m = '{1, 32767, -32768, -32768, -1, 32767, 32767, -32768, 0};
        send_matrix(m);
        for (int k = 0; k < 4; k++)
        begin
            for (int i = 0; i < 9; i++) m[i] = lim[(i + k) % 4];
            send_matrix(m);
        end
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == N_RANDOM - 200) quiet = 1'b1;
            if ($urandom_range(0, 9) < 7) build_rotation(m);
            else for (int i = 0; i < 9; i++) m[i] = rand_elem();
            send_matrix(m);
        end
        in_valid <= 1'b0;
        stimulus_done = 1'b1;
    end

    // receiver: random stalls, one long hold-off early on
    initial
    begin
        int stall;
        @(posedge rst_n);
        @(negedge clk);
        out_ready <= 1'b0;
        stall = 0;
        while (stall < 150)
        begin
            @(negedge clk);
            stall++;
        end
        forever
        begin
            if (!quiet && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                stall = $urandom_range(1, 3);
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        wait (stimulus_done);
        while (pending != 0) @(posedge clk);
        repeat (LATENCY + QUIET_TAIL) @(posedge clk);
        $display("%0d matrices sent, %0d quaternions checked, %0d degenerate",
                 sent, quats_seen, degen_seen);
        $display("branches: trace %0d, r0c0 %0d, r1c1 %0d, r2c2 %0d",
                 branch_hits[0], branch_hits[1], branch_hits[2], branch_hits[3]);
        if (errors == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
